[rtl/core/siwe_message_field_extractor_macros.svh]
// Assertion macros for the sign-in message field extractor
`ifndef SIWE_MESSAGE_FIELD_EXTRACTOR_MACROS_SVH
`define SIWE_MESSAGE_FIELD_EXTRACTOR_MACROS_SVH

// label: implication checked at every rising clock edge outside reset
`define SMFE_ASSERT_IMP(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// label: implication checked in the cycle after the trigger
`define SMFE_ASSERT_NEXT(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

[rtl/core/smfe_pkg.sv]
// ----------------------------------------------------------------------------
// smfe_pkg
// Shared types and constants of the sign-in message field extractor.
// ----------------------------------------------------------------------------
package smfe_pkg;

    localparam int MAX_FIELD_BYTES = 64;
    localparam int NUM_REGS = 6;

    typedef enum logic [1:0] {
        PH_START   = 2'd0,
        PH_PREFIX  = 2'd1,
        PH_CAPTURE = 2'd2,
        PH_SKIP    = 2'd3
    } phase_t;

    localparam logic [2:0] REG_DOMAIN   = 3'd0;
    localparam logic [2:0] REG_ADDRESS  = 3'd1;
    localparam logic [2:0] REG_URI      = 3'd2;
    localparam logic [2:0] REG_VERSION  = 3'd3;
    localparam logic [2:0] REG_NONCE    = 3'd4;
    localparam logic [2:0] REG_DATETIME = 3'd5;

    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_NUL = 8'h00;

    // one result beat
    typedef struct packed {
        logic [2:0] field_id;
        logic       char_valid;
        logic [7:0] char_value;
        logic [5:0] char_index;
        logic       field_end;
        logic [5:0] value_len;
        logic       message_done;
        logic       run_last;
    } rec_t;

    // what the front part hands the back part for one byte
    typedef struct packed {
        logic has_char;
        logic has_stat;
        rec_t ch;
        rec_t st;
    } job_t;

    function automatic logic [4:0] pfx_len(input logic [2:0] p);
        logic [4:0] r;
        begin
            case (p)
                3'd0:    r = 5'd5;
                3'd1:    r = 5'd9;
                3'd2:    r = 5'd7;
                3'd3:    r = 5'd11;
                default: r = 5'd17;
            endcase
            return r;
        end
    endfunction

    // prefix text packed right-aligned, first character in the top byte
    function automatic logic [7:0] pfx_char(input logic [2:0] p, input logic [4:0] i);
        logic [135:0] s;
        logic [4:0]   n;
        logic [7:0]   r;
        begin
            case (p)
                3'd0:    s = 136'("URI: ");
                3'd1:    s = 136'("Version: ");
                3'd2:    s = 136'("Nonce: ");
                3'd3:    s = 136'("Issued At: ");
                default: s = 136'("Expiration Time: ");
            endcase
            n = pfx_len(p);
            r = 8'h00;
            if (i < n) r = s[8'(n - 5'd1 - i) * 8'd8 +: 8];
            return r;
        end
    endfunction

endpackage

[rtl/core/smfe_front.sv]
// ----------------------------------------------------------------------------
// smfe_front
// Accepts message bytes, tracks line and prefix state, builds result jobs.
// ----------------------------------------------------------------------------
module smfe_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_index,
    input  logic [6:0]        cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_byte_value,
    input  logic              s_last_byte,
    output logic              job_valid,
    input  logic              job_ready,
    output smfe_pkg::job_t    job
);

    logic [6:0] limit_reg [smfe_pkg::NUM_REGS];
    logic [2:0] line_reg, line_next;
    smfe_pkg::phase_t phase_reg, phase_next;
    logic [2:0] field_reg, field_next;
    logic [4:0] ppos_reg, ppos_next;
    logic [5:0] count_reg, count_next;
    logic [4:0] found_reg, found_next;
    logic       fin_reg, fin_next;

    logic       acc;
    logic [7:0] b;
    logic       consumed, done, has_char, has_end;
    logic [2:0] end_field;
    logic [5:0] end_len;
    logic [5:0] cap;
    logic [2:0] p;
    logic       hit;

    assign s_ready   = job_ready;
    assign job_valid = s_valid;
    assign acc       = s_valid && s_ready;
    assign b         = s_byte_value;

    function automatic logic [5:0] field_cap(input logic [6:0] lim);
        logic [6:0] r;
        begin
            r = (lim > 7'(smfe_pkg::MAX_FIELD_BYTES)) ? 7'(smfe_pkg::MAX_FIELD_BYTES) : lim;
            if (r == 7'd0) r = 7'd1;
            return 6'(r - 7'd1);
        end
    endfunction

    function automatic logic [2:0] reg_of(input logic [2:0] f);
        return (f <= 3'd4) ? f : smfe_pkg::REG_DATETIME;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg[smfe_pkg::REG_DOMAIN]   <= 7'd64;
            limit_reg[smfe_pkg::REG_ADDRESS]  <= 7'd64;
            limit_reg[smfe_pkg::REG_URI]      <= 7'd64;
            limit_reg[smfe_pkg::REG_VERSION]  <= 7'd5;
            limit_reg[smfe_pkg::REG_NONCE]    <= 7'd32;
            limit_reg[smfe_pkg::REG_DATETIME] <= 7'd32;
        end else if (cfg_wr_en && cfg_index < 3'(smfe_pkg::NUM_REGS)) begin
            limit_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb begin
        line_next  = line_reg;
        phase_next = phase_reg;
        field_next = field_reg;
        ppos_next  = ppos_reg;
        count_next = count_reg;
        found_next = found_reg;
        fin_next   = fin_reg;
        consumed   = 1'b0;
        done       = 1'b0;
        has_char   = 1'b0;
        has_end    = 1'b0;
        end_field  = 3'd0;
        end_len    = 6'd0;
        hit        = 1'b0;
        p          = 3'(field_reg - 3'd2);

        unique case (phase_reg)
            smfe_pkg::PH_START: begin
                if (line_reg < 3'd2) begin
                    field_next = line_reg;
                    count_next = 6'd0;
                    phase_next = smfe_pkg::PH_CAPTURE;
                    if (field_cap(limit_reg[reg_of(line_reg)]) == 6'd0) begin
                        has_end    = 1'b1;
                        end_field  = line_reg;
                        phase_next = smfe_pkg::PH_SKIP;
                    end
                end else begin
                    phase_next = smfe_pkg::PH_SKIP;
                    if (line_reg >= 3'd4) begin
                        // first unfound prefix whose opening letter matches
                        for (int k = 0; k < 5; k++) begin
                            if (!hit && !found_reg[k] && smfe_pkg::pfx_char(3'(k), 5'd0) == b) begin
                                hit        = 1'b1;
                                field_next = 3'(k + 2);
                                ppos_next  = 5'd1;
                                phase_next = smfe_pkg::PH_PREFIX;
                                consumed   = 1'b1;
                            end
                        end
                    end
                end
            end
            smfe_pkg::PH_PREFIX: begin
                if (smfe_pkg::pfx_char(p, ppos_reg) == b && ppos_reg < smfe_pkg::pfx_len(p)) begin
                    consumed  = 1'b1;
                    ppos_next = ppos_reg + 5'd1;
                    if (ppos_next >= smfe_pkg::pfx_len(p)) begin
                        found_next = found_reg | (5'd1 << p);
                        count_next = 6'd0;
                        phase_next = smfe_pkg::PH_CAPTURE;
                        if (field_cap(limit_reg[reg_of(field_reg)]) == 6'd0) begin
                            has_end    = 1'b1;
                            end_field  = field_reg;
                            phase_next = smfe_pkg::PH_SKIP;
                        end
                    end
                end else begin
                    phase_next = smfe_pkg::PH_SKIP;
                end
            end
            default: ;
        endcase

        cap = field_cap(limit_reg[reg_of(field_next)]);
        if (!consumed && phase_next == smfe_pkg::PH_CAPTURE) begin
            if (count_next >= cap || b == smfe_pkg::CH_SP || b == smfe_pkg::CH_NL
                    || b == smfe_pkg::CH_NUL) begin
                has_end    = 1'b1;
                end_field  = field_next;
                end_len    = count_next;
                phase_next = smfe_pkg::PH_SKIP;
            end else begin
                consumed   = 1'b1;
                has_char   = 1'b1;
                count_next = count_next + 6'd1;
                if (count_next >= cap) begin
                    has_end    = 1'b1;
                    end_field  = field_next;
                    end_len    = count_next;
                    phase_next = smfe_pkg::PH_SKIP;
                end
            end
        end

        if (!consumed && phase_next == smfe_pkg::PH_SKIP) begin
            if (b == smfe_pkg::CH_NL) begin
                if (line_reg < 3'd4) line_next = line_reg + 3'd1;
                phase_next = smfe_pkg::PH_START;
            end else if (b == smfe_pkg::CH_NUL) begin
                done = 1'b1;
            end
        end

        if (s_last_byte) done = 1'b1;
        if (done) begin
            if (phase_next == smfe_pkg::PH_CAPTURE && !has_end) begin
                has_end   = 1'b1;
                end_field = field_next;
                end_len   = count_next;
            end
            fin_next = 1'b1;
        end

        job              = '0;
        job.has_char     = has_char && !fin_reg;
        job.has_stat     = (has_end || done) && !fin_reg;
        job.ch.field_id  = field_next;
        job.ch.char_valid = 1'b1;
        job.ch.char_value = b;
        job.ch.char_index = 6'(count_next - 6'd1);
        job.ch.run_last  = !(has_end || done);
        job.st.field_id  = has_end ? end_field : 3'd0;
        job.st.field_end = has_end;
        job.st.value_len = has_end ? end_len : 6'd0;
        job.st.message_done = done;
        job.st.run_last  = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg  <= 3'd0;
            phase_reg <= smfe_pkg::PH_START;
            field_reg <= 3'd0;
            ppos_reg  <= 5'd0;
            count_reg <= 6'd0;
            found_reg <= 5'd0;
            fin_reg   <= 1'b0;
        end else if (acc && !fin_reg) begin
            line_reg  <= line_next;
            phase_reg <= phase_next;
            field_reg <= field_next;
            ppos_reg  <= ppos_next;
            count_reg <= count_next;
            found_reg <= found_next;
            fin_reg   <= fin_next;
        end
    end

endmodule

[rtl/core/smfe_queue.sv]
// ----------------------------------------------------------------------------
// smfe_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module smfe_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  smfe_pkg::job_t in_job,
    output logic           out_valid,
    input  logic           out_ready,
    output smfe_pkg::job_t out_job
);

    smfe_pkg::job_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_job   = mem_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= in_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

[rtl/core/smfe_back.sv]
// ----------------------------------------------------------------------------
// smfe_back
// Expands each job into its character and status beats.
// ----------------------------------------------------------------------------
module smfe_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           job_valid,
    output logic           job_ready,
    input  smfe_pkg::job_t job,
    output logic           m_valid,
    input  logic           m_ready,
    output smfe_pkg::rec_t m_rec
);

    logic sent_reg;   // character beat of the head job already delivered
    logic two, fire;

    assign two       = job.has_char && job.has_stat;
    assign m_valid   = job_valid && (job.has_char || job.has_stat);
    assign m_rec     = (job.has_char && !sent_reg) ? job.ch : job.st;
    assign fire      = m_valid && m_ready;
    // empty jobs drop at once
    assign job_ready = (job_valid && !(job.has_char || job.has_stat))
                       || (fire && (!two || sent_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sent_reg <= 1'b0;
        end else if (fire) begin
            sent_reg <= two && !sent_reg;
        end
    end

endmodule

[rtl/core/siwe_message_field_extractor.sv]
// ----------------------------------------------------------------------------
// siwe_message_field_extractor
// Streams a sign-in message byte by byte and emits captured field beats.
// ----------------------------------------------------------------------------
// channel | dir | handshake       | payload
// s_      | in  | s_valid/s_ready | byte_value, last_byte
// m_      | out | m_valid/m_ready | field_id .. run_last
// cfg_    | in  | cfg_wr_en       | cfg_index, cfg_data
// One byte accepted per cycle while the queue has room; the front decides a byte in the cycle it lands.
// A byte yields up to two beats, drained one per cycle while m_ready is high from a 2-entry queue.
// Bytes yielding two beats hold their queue entry until both are sent; s_ready drops when full.
// Synchronous active-low reset clears parse state and reloads limits.
// ----------------------------------------------------------------------------
module siwe_message_field_extractor (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_index,
    input  logic [6:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte_value,
    input  logic       s_last_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_field_id,
    output logic       m_char_valid,
    output logic [7:0] m_char_value,
    output logic [5:0] m_char_index,
    output logic       m_field_end,
    output logic [5:0] m_value_len,
    output logic       m_message_done,
    output logic       m_run_last
);

    smfe_pkg::job_t fj, qj;
    smfe_pkg::rec_t rec;
    logic f_valid, f_ready, q_valid, q_ready;

    smfe_front u_front (
        .aclk, .aresetn, .cfg_wr_en, .cfg_index, .cfg_data,
        .s_valid, .s_ready, .s_byte_value, .s_last_byte,
        .job_valid(f_valid), .job_ready(f_ready), .job(fj)
    );

    smfe_queue u_queue (
        .aclk, .aresetn,
        .in_valid(f_valid), .in_ready(f_ready), .in_job(fj),
        .out_valid(q_valid), .out_ready(q_ready), .out_job(qj)
    );

    smfe_back u_back (
        .aclk, .aresetn,
        .job_valid(q_valid), .job_ready(q_ready), .job(qj),
        .m_valid, .m_ready, .m_rec(rec)
    );

    assign m_field_id     = rec.field_id;
    assign m_char_valid   = rec.char_valid;
    assign m_char_value   = rec.char_value;
    assign m_char_index   = rec.char_index;
    assign m_field_end    = rec.field_end;
    assign m_value_len    = rec.value_len;
    assign m_message_done = rec.message_done;
    assign m_run_last     = rec.run_last;

endmodule

[rtl/core/smfe_checker.sv]
// ----------------------------------------------------------------------------
// smfe_checker
// Port-level checks of the field extractor, bound to the top level.
// ----------------------------------------------------------------------------
`include "siwe_message_field_extractor_macros.svh"

module smfe_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_field_id,
    input logic       m_char_valid,
    input logic       m_field_end,
    input logic       m_message_done,
    input logic       m_run_last
);

    `SMFE_ASSERT_IMP(a_char_not_status, aclk, aresetn, m_valid && m_char_valid, !m_field_end && !m_message_done)
    `SMFE_ASSERT_IMP(a_status_is_last, aclk, aresetn, m_valid && !m_char_valid, m_run_last)
    `SMFE_ASSERT_IMP(a_field_range, aclk, aresetn, m_valid, m_field_id != 3'd7)
    `SMFE_ASSERT_NEXT(a_done_final, aclk, aresetn, m_valid && m_ready && m_message_done, !m_valid)

endmodule

bind siwe_message_field_extractor smfe_checker u_smfe_checker (
    .aclk, .aresetn, .m_valid, .m_ready, .m_field_id, .m_char_valid,
    .m_field_end, .m_message_done, .m_run_last
);
